// ===== rtl/hrfh_pkg.sv =====
// ----------------------------------------------------------------------------
// hrfh_pkg
// Shared types and constants for the hex record to flash halfword converter.
// ----------------------------------------------------------------------------
package hrfh_pkg;

	typedef struct packed {
		logic [7:0] character;
		logic       record_start;
	} in_item_t;

	typedef struct packed {
		logic [31:0] flash_address;
		logic [15:0] halfword;
		logic        last_of_record;
	} out_item_t;

	localparam logic [15:0] BASE_HIGH_RESET = 16'h0800;
	localparam logic [9:0]  POS_MAX         = 10'd1023;
	localparam logic [9:0]  POS_TYPE        = 10'd8;
	localparam logic [9:0]  POS_DATA        = 10'd9;
	localparam logic [7:0]  CHAR_ZERO       = 8'd48;
	localparam logic [7:0]  CHAR_NINE       = 8'd57;
	localparam logic [7:0]  ALPHA_OFFSET    = 8'd55;

	function automatic logic [3:0] nibble_of(input logic [7:0] c);
		logic [7:0] d;
		begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				d = c - CHAR_ZERO;
			end else begin
				d = c - ALPHA_OFFSET;
			end
			nibble_of = d[3:0];
		end
	endfunction

endpackage

// ===== rtl/hrfh_parser.sv =====
// ----------------------------------------------------------------------------
// hrfh_parser
// Record parse state and per-character update; forms one halfword result.
// ----------------------------------------------------------------------------
module hrfh_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  hrfh_pkg::in_item_t item,
	input  logic [15:0]       base_high,
	output logic              produced,
	output hrfh_pkg::out_item_t result
);
	import hrfh_pkg::*;

	logic [9:0]  char_position_q;
	logic [7:0]  byte_count_q;
	logic [15:0] load_offset_q;
	logic        is_data_record_q;
	logic [6:0]  halfword_index_q;
	logic [11:0] partial_nibbles_q;

	logic [9:0]  pos;
	logic        is_data;
	logic [6:0]  hw_idx;
	logic [11:0] partial;
	logic [3:0]  nib;
	logic [6:0]  total;
	logic [7:0]  hw_idx_inc;

	logic [9:0]  char_position_d;
	logic [7:0]  byte_count_d;
	logic [15:0] load_offset_d;
	logic        is_data_record_d;
	logic [6:0]  halfword_index_d;
	logic [11:0] partial_nibbles_d;

	always_comb begin
		pos        = item.record_start ? '0 : char_position_q;
		is_data    = item.record_start ? 1'b0 : is_data_record_q;
		hw_idx     = item.record_start ? '0 : halfword_index_q;
		partial    = item.record_start ? '0 : partial_nibbles_q;
		nib        = nibble_of(item.character);
		total      = byte_count_q[7:1];
		hw_idx_inc = {1'b0, hw_idx} + 8'd1;

		byte_count_d      = byte_count_q;
		load_offset_d     = load_offset_q;
		is_data_record_d  = is_data;
		halfword_index_d  = hw_idx;
		partial_nibbles_d = partial;
		produced          = 1'b0;

		result.flash_address  = {base_high, load_offset_q} + {24'd0, hw_idx, 1'b0};
		result.halfword       = {partial[3:0], nib, partial[11:8], partial[7:4]};
		result.last_of_record = (hw_idx_inc == {1'b0, total});

		priority if (pos == 10'd1 || pos == 10'd2) begin
			byte_count_d = {byte_count_q[3:0], nib};
		end else if (pos >= 10'd3 && pos <= 10'd6) begin
			load_offset_d = {load_offset_q[11:0], nib};
		end else if (pos == POS_TYPE) begin
			is_data_record_d  = (item.character == CHAR_ZERO);
			halfword_index_d  = '0;
			partial_nibbles_d = '0;
		end else if (pos >= POS_DATA && is_data) begin
			if (pos[1:0] != 2'd0) begin
				partial_nibbles_d = {partial[7:0], nib};
			end else begin
				if (hw_idx < total) begin
					produced         = 1'b1;
					halfword_index_d = hw_idx_inc[6:0];
				end
				partial_nibbles_d = '0;
			end
		end else begin
		end

		char_position_d = (pos < POS_MAX) ? pos + 10'd1 : pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_position_q   <= '0;
			byte_count_q      <= '0;
			load_offset_q     <= '0;
			is_data_record_q  <= 1'b0;
			halfword_index_q  <= '0;
			partial_nibbles_q <= '0;
		end else if (advance) begin
			char_position_q   <= char_position_d;
			byte_count_q      <= byte_count_d;
			load_offset_q     <= load_offset_d;
			is_data_record_q  <= is_data_record_d;
			halfword_index_q  <= halfword_index_d;
			partial_nibbles_q <= partial_nibbles_d;
		end
	end

endmodule

// ===== rtl/hex_record_to_flash_halfwords_unit.sv =====
// ----------------------------------------------------------------------------
// hex_record_to_flash_halfwords_unit
// Streams hex record characters and emits addressed flash halfwords.
// ----------------------------------------------------------------------------
// path: a result passes from the input register through the parse stage into the result register
// throughput: one character per cycle while the output is not stalled, set by the
// single parse stage between the input register and the result register
// reset: parse state cleared, base_high back to 0x0800, both stages empty
module hex_record_to_flash_halfwords_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  hrfh_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output hrfh_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import hrfh_pkg::*;

	logic      [15:0] base_high_q;
	in_item_t         item_s1;
	logic             valid_s1;
	out_item_t        out_q;
	logic             out_valid_q;
	logic             advance;
	logic             produced;
	out_item_t        result;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	hrfh_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.item     (item_s1),
		.base_high(base_high_q),
		.produced (produced),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_high_q <= BASE_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_high_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produced) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produced) begin
			out_q <= result;
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for hex_record_to_flash_halfwords_unit. Feeds hex record
// text one character per transaction (directed records, well-formed random
// records, broken records, noise and one over-long record) under several
// base_high settings and idle/stall patterns. An in-bench parser predicts
// every addressed halfword, and each output transaction is checked in order.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hrfh_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int SETTLE_CYCLES  = 4;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_item   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data  = '0;

	// parser state mirrored in the bench
	logic [9:0]  char_pos;
	logic [7:0]  rec_byte_count;
	logic [15:0] rec_offset;
	logic        rec_is_data;
	logic [6:0]  hw_index;
	logic [11:0] nibble_acc;
	logic [15:0] base_high_q;

	out_item_t expected_halfwords[$];
	int        error_count    = 0;
	int        send_idle_pct  = 0;
	int        recv_stall_pct = 0;
	int        quiet_cycles   = 0;

	hex_record_to_flash_halfwords_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [3:0] char_nibble(input logic [7:0] c);
		logic [7:0] d;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d = c - CHAR_ZERO;
		end else begin
			d = c - ALPHA_OFFSET;
		end
		return d[3:0];
	endfunction

	function automatic bit parse_char(input in_item_t it, output out_item_t res);
		logic [3:0] nib;
		logic [9:0] rel;
		logic [6:0] total;
		bit         emit;
		emit = 1'b0;
		res  = '0;
		nib  = char_nibble(it.character);
		if (it.record_start) begin
			char_pos    = '0;
			rec_is_data = 1'b0;
			hw_index    = '0;
			nibble_acc  = '0;
		end
		if (char_pos == 10'd1 || char_pos == 10'd2) begin
			rec_byte_count = {rec_byte_count[3:0], nib};
		end else if (char_pos >= 10'd3 && char_pos <= 10'd6) begin
			rec_offset = {rec_offset[11:0], nib};
		end else if (char_pos == POS_TYPE) begin
			rec_is_data = (it.character == CHAR_ZERO);
			hw_index    = '0;
			nibble_acc  = '0;
		end else if (char_pos >= POS_DATA && rec_is_data) begin
			rel = char_pos - POS_DATA;
			if (rel[1:0] != 2'd3) begin
				nibble_acc = {nibble_acc[7:0], nib};
			end else begin
				total = rec_byte_count[7:1];
				if (hw_index < total) begin
					res.flash_address  = {base_high_q, rec_offset} + {24'd0, hw_index, 1'b0};
					res.halfword       = {nibble_acc[3:0], nib, nibble_acc[11:8], nibble_acc[7:4]};
					res.last_of_record = (32'(hw_index) + 1 == 32'(total));
					hw_index           = hw_index + 7'd1;
					emit               = 1'b1;
				end
				nibble_acc = '0;
			end
		end
		if (char_pos != POS_MAX) begin
			char_pos = char_pos + 10'd1;
		end
		return emit;
	endfunction

	// output side: random stall and in-order check
	always @(posedge clk) begin
		out_item_t exp_item;
		out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_halfwords.size() == 0) begin
				error_count++;
				$display("%0t unexpected transaction: expected none, actual addr %h hw %h last %b",
					$time, out_item.flash_address, out_item.halfword, out_item.last_of_record);
			end else begin
				exp_item = expected_halfwords.pop_front();
				if (out_item.flash_address !== exp_item.flash_address ||
				    out_item.halfword !== exp_item.halfword ||
				    out_item.last_of_record !== exp_item.last_of_record) begin
					error_count++;
					$display("%0t mismatch: expected addr %h hw %h last %b, actual addr %h hw %h last %b",
						$time, exp_item.flash_address, exp_item.halfword,
						exp_item.last_of_record, out_item.flash_address,
						out_item.halfword, out_item.last_of_record);
				end
			end
		end
	end

	// watchdog on transaction activity
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_char(input logic [7:0] ch, input logic st);
		in_item_t  it;
		out_item_t res;
		it.character    = ch;
		it.record_start = st;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		if (parse_char(it, res)) begin
			expected_halfwords.push_back(res);
		end
	endtask

	task automatic send_string(input string s, input logic first_start);
		for (int i = 0; i < s.len(); i++) begin
			send_char(s[i], first_start && i == 0);
		end
	endtask

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		if (v < 4'd10) begin
			return CHAR_ZERO + 8'(v);
		end
		return ($urandom_range(1) ? "a" : "A") + 8'(v) - 8'd10;
	endfunction

	task automatic send_record(input logic [7:0] count, input logic [15:0] offs,
			input logic [7:0] rtype, input bit with_start, input int cut);
		logic [7:0] chars[$];
		int         remaining;
		remaining = cut;
		chars.push_back(":");
		chars.push_back(hex_digit(count[7:4]));
		chars.push_back(hex_digit(count[3:0]));
		for (int i = 3; i >= 0; i--) begin
			chars.push_back(hex_digit(offs[i*4 +: 4]));
		end
		chars.push_back("0");
		chars.push_back(rtype);
		repeat (2 * int'(count) + 2) begin
			if ($urandom_range(31) == 0) begin
				chars.push_back(8'($urandom_range(255)));
			end else begin
				chars.push_back(hex_digit(4'($urandom_range(15))));
			end
		end
		while (remaining > 0 && chars.size() > 1) begin
			void'(chars.pop_back());
			remaining--;
		end
		foreach (chars[i]) begin
			send_char(chars[i], with_start && i == 0);
		end
	endtask

	task automatic write_base_high(input logic [15:0] value);
		in_valid <= 1'b0;
		while (expected_halfwords.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid   <= 1'b0;
		base_high_q  = value;
	endtask

	// first character without any record start, odd count, non-hex and extreme
	// characters, offset at the top, then a non-data record
	task automatic test_directed();
		send_string(":03FFFF00A1b2", 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b0);
		send_string("5E", 1'b0);
		send_string(":00000001", 1'b1);
	endtask

	task automatic test_address_wrap();
		write_base_high(16'hFFFF);
		send_string(":04FFFE0012345678C3", 1'b1);
	endtask

	task automatic test_data_records(input int n_records);
		logic [7:0] count;
		logic [7:0] rtype;
		int         r;
		int         cut;
		repeat (n_records) begin
			r = $urandom_range(99);
			if (r < 4) begin
				count = 8'hFF;
			end else if (r < 12) begin
				count = 8'($urandom_range(21, 254));
			end else begin
				count = 8'($urandom_range(0, 20));
			end
			rtype = ($urandom_range(99) < 85) ? CHAR_ZERO : 8'($urandom_range(255));
			cut   = ($urandom_range(99) < 10) ? $urandom_range(1, 2 * int'(count) + 10) : 0;
			send_record(count, 16'($urandom), rtype, $urandom_range(99) >= 5, cut);
		end
	endtask

	task automatic test_noise(input int n_chars);
		repeat (n_chars) begin
			send_char(8'($urandom_range(255)), $urandom_range(15) == 0);
		end
	endtask

	// position counter saturation, then a clean record
	task automatic test_long_record();
		send_record(8'hFF, 16'($urandom), CHAR_ZERO, 1'b1, 0);
		repeat (560) begin
			send_char(hex_digit(4'($urandom_range(15))), 1'b0);
		end
		send_record(8'h04, 16'($urandom), CHAR_ZERO, 1'b1, 0);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input logic [15:0] base);
		write_base_high(base);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		test_data_records(2);
		test_noise(40);
	endtask

	initial begin
		int waited;
		char_pos       = '0;
		rec_byte_count = '0;
		rec_offset     = '0;
		rec_is_data    = 1'b0;
		hw_index       = '0;
		nibble_acc     = '0;
		base_high_q    = BASE_HIGH_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_address_wrap();
		run_phase(0, 0, 16'h0000);
		run_phase(66, 0, 16'($urandom));
		run_phase(0, 66, 16'hFFFF);
		run_phase(35, 35, 16'($urandom));
		test_long_record();
		run_phase(0, 0, BASE_HIGH_RESET);

		in_valid <= 1'b0;
		waited = 0;
		while (expected_halfwords.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (expected_halfwords.size() != 0) begin
			$display("%0t missing transactions: %0d expected halfwords never arrived",
				$time, expected_halfwords.size());
			error_count += expected_halfwords.size();
		end
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== hex_record_to_flash_halfwords_unit.f =====
rtl/hrfh_pkg.sv
rtl/hrfh_parser.sv
rtl/hex_record_to_flash_halfwords_unit.sv
tb/testbench.sv
